>>> design/wvm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wvm_pkg
// Shared constants, codes and types of the wavetable voice mixer.
// ----------------------------------------------------------------------------
package wvm_pkg;

    // Block configuration
    localparam int NUM_VOICES       = 4;
    localparam int NUM_TRACKS       = 4;
    localparam int NUM_WAVE_SAMPLES = 32;
    localparam int NUM_WAVES        = 16;
    localparam int SAMPLE_RATE      = 44100;

    // Item field widths
    localparam int VOICE_W = 2;
    localparam int TRACK_W = 2;
    localparam int KIND_W  = 3;
    localparam int WAVE_W  = 4;
    localparam int FREQ_W  = 15;
    localparam int AMP_W   = 16;
    localparam int IDX_W   = 5;
    localparam int VAL_W   = 17;
    localparam int SMP_W   = 16;

    // Stream widths
    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 24;

    // Wave table geometry
    localparam int SLOT_W    = $clog2(NUM_WAVE_SAMPLES);
    localparam int SLOT_LSB  = 12;
    localparam int TBL_DEPTH = NUM_WAVES * NUM_WAVE_SAMPLES;
    localparam int TA_W      = $clog2(TBL_DEPTH);
    localparam int WV_W      = TA_W - SLOT_W;

    // Phase counters
    localparam int CTR_DEPTH = NUM_VOICES * NUM_TRACKS;
    localparam int CI_W      = (CTR_DEPTH > 1) ? $clog2(CTR_DEPTH) : 1;
    localparam int PHASE_W   = 32;

    // Phase step: step = (f << STEP_SHIFT) mod 2^32 / SAMPLE_RATE
    localparam int STEP_SHIFT = SLOT_W + SLOT_LSB;
    localparam int F_W        = PHASE_W - STEP_SHIFT;
    localparam longint RECIP_M_L = (longint'(1) << (STEP_SHIFT + F_W)) / SAMPLE_RATE;
    localparam int RM_W       = $clog2(RECIP_M_L + 1);
    localparam logic [RM_W-1:0] RECIP_M = RM_W'(RECIP_M_L);
    localparam int Q_W        = RM_W + 1;
    localparam int SR_W       = $clog2(SAMPLE_RATE + 1);
    localparam int QS_W       = Q_W + SR_W;

    // Frequency modulation: f = (freq * (mix + 2^15)) >> 16
    localparam int FM_SHIFT = 16;
    localparam int FMP_W    = FM_SHIFT + F_W;
    localparam logic [PHASE_W-1:0] FM_BIAS = PHASE_W'(1) << 15;

    // Q15 scaling and datapath widths
    localparam int Q15   = 15;
    localparam int MIX_W = 32;
    localparam int S_W   = VAL_W + AMP_W - Q15 + 1;

    // Command queue
    localparam int FIFO_DEPTH = 4;
    localparam int FP_W       = $clog2(FIFO_DEPTH);

    // Codes
    localparam logic [WAVE_W-1:0] CONST_WAVE = 4'd15;
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_TRACK = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE = 3'd0,
        KIND_MOD  = 3'd1,
        KIND_ADD  = 3'd2,
        KIND_REPL = 3'd3,
        KIND_FM   = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FMUL,
        S_RECIP,
        S_CORR,
        S_STEP,
        S_PHASE,
        S_SCALE,
        S_MIX
    } t_back_state;

    // Classified item as it travels from front to back
    typedef struct packed {
        logic                     is_load;
        logic                     first;
        logic                     last;
        t_kind                    kind;
        logic                     is_const;
        logic                     wave_ok;
        logic                     cvalid;
        logic [CI_W-1:0]          ci;
        logic [VOICE_W-1:0]       voice;
        logic [WV_W-1:0]          wave;
        logic [IDX_W-1:0]         idx;
        logic [FREQ_W-1:0]        freq;
        logic signed [AMP_W-1:0]  amp;
        logic signed [AMP_W-1:0]  bias;
        logic signed [VAL_W-1:0]  value;
    } t_cmd;

endpackage
`default_nettype wire

>>> design/wvm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wvm_front
// Input stage: accept items, decode them into commands and hold one for the queue.
// ----------------------------------------------------------------------------
module wvm_front (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    input  wire [wvm_pkg::S_TDATA_W-1:0]     i_s_tdata,
    input  wire                              i_s_tlast,
    input  wire [wvm_pkg::S_TUSER_W-1:0]     i_s_tuser,
    output logic                             o_cmd_valid,
    input  wire                              i_cmd_ready,
    output wvm_pkg::t_cmd                    o_cmd
);

    localparam int VOICE_LSB = 0;
    localparam int TRACK_LSB = VOICE_LSB + wvm_pkg::VOICE_W;
    localparam int FIRST_LSB = TRACK_LSB + wvm_pkg::TRACK_W;
    localparam int WAVE_LSB  = FIRST_LSB + 1;
    localparam int FREQ_LSB  = WAVE_LSB + wvm_pkg::WAVE_W;
    localparam int AMP_LSB   = FREQ_LSB + wvm_pkg::FREQ_W;
    localparam int BIAS_LSB  = AMP_LSB + wvm_pkg::AMP_W;
    localparam int IDX_LSB   = BIAS_LSB + wvm_pkg::AMP_W;
    localparam int VAL_LSB   = IDX_LSB + wvm_pkg::IDX_W;

    logic                          r_valid;
    wvm_pkg::t_cmd                 r_cmd;
    wvm_pkg::t_cmd                 w_cmd;
    logic [wvm_pkg::VOICE_W-1:0]   w_voice;
    logic [wvm_pkg::TRACK_W-1:0]   w_track;
    logic [wvm_pkg::WAVE_W-1:0]    w_wave;
    logic                          w_take;

    assign o_s_tready  = !r_valid || i_cmd_ready;
    assign w_take      = i_s_tvalid && o_s_tready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_comb begin
        w_voice = i_s_tdata[VOICE_LSB +: wvm_pkg::VOICE_W];
        w_track = i_s_tdata[TRACK_LSB +: wvm_pkg::TRACK_W];
        w_wave  = i_s_tdata[WAVE_LSB +: wvm_pkg::WAVE_W];

        w_cmd.is_load  = (i_s_tuser[0] == wvm_pkg::ACT_LOAD);
        w_cmd.kind     = wvm_pkg::t_kind'(i_s_tuser[1 +: wvm_pkg::KIND_W]);
        w_cmd.first    = i_s_tdata[FIRST_LSB];
        w_cmd.last     = i_s_tlast;
        w_cmd.is_const = (w_wave == wvm_pkg::CONST_WAVE);
        w_cmd.wave_ok  = (32'(w_wave) < wvm_pkg::NUM_WAVES);
        // counters exist only for voices and tracks inside the configuration
        w_cmd.cvalid   = (32'(w_voice) < wvm_pkg::NUM_VOICES)
                      && (32'(w_track) < wvm_pkg::NUM_TRACKS);
        w_cmd.ci       = wvm_pkg::CI_W'(8'(w_voice) * 8'(wvm_pkg::NUM_TRACKS) + 8'(w_track));
        w_cmd.voice    = w_voice;
        w_cmd.wave     = wvm_pkg::WV_W'(w_wave);
        w_cmd.idx      = i_s_tdata[IDX_LSB +: wvm_pkg::IDX_W];
        w_cmd.freq     = i_s_tdata[FREQ_LSB +: wvm_pkg::FREQ_W];
        w_cmd.amp      = i_s_tdata[AMP_LSB +: wvm_pkg::AMP_W];
        w_cmd.bias     = i_s_tdata[BIAS_LSB +: wvm_pkg::AMP_W];
        w_cmd.value    = i_s_tdata[VAL_LSB +: wvm_pkg::VAL_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd <= w_cmd;
        end
    end

endmodule
`default_nettype wire

>>> design/wvm_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wvm_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module wvm_fifo (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push_valid,
    output logic              o_push_ready,
    input  wire wvm_pkg::t_cmd i_push_data,
    output logic              o_pop_valid,
    input  wire               i_pop_ready,
    output wvm_pkg::t_cmd     o_pop_data
);

    wvm_pkg::t_cmd           r_mem [wvm_pkg::FIFO_DEPTH];
    logic [wvm_pkg::FP_W:0]  r_wr_ptr;
    logic [wvm_pkg::FP_W:0]  r_rd_ptr;
    logic                    w_full;
    logic                    w_empty;
    logic                    w_push;
    logic                    w_pop;

    assign w_empty      = (r_wr_ptr == r_rd_ptr);
    assign w_full       = (r_wr_ptr[wvm_pkg::FP_W-1:0] == r_rd_ptr[wvm_pkg::FP_W-1:0])
                       && (r_wr_ptr[wvm_pkg::FP_W] != r_rd_ptr[wvm_pkg::FP_W]);
    assign o_push_ready = !w_full;
    assign o_pop_valid  = !w_empty;
    assign o_pop_data   = r_mem[r_rd_ptr[wvm_pkg::FP_W-1:0]];
    assign w_push       = i_push_valid && !w_full;
    assign w_pop        = i_pop_ready && !w_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr[wvm_pkg::FP_W-1:0]] <= i_push_data;
        end
    end

endmodule
`default_nettype wire

>>> design/wvm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wvm_back
// Execution sequencer: wave table, phase counters, running mix, output register.
// ----------------------------------------------------------------------------
module wvm_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cmd_valid,
    output logic                         o_cmd_ready,
    input  wire wvm_pkg::t_cmd           i_cmd,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [wvm_pkg::SMP_W-1:0]    o_sample,
    output logic [wvm_pkg::VOICE_W-1:0]  o_voice
);

    localparam int MP_W = wvm_pkg::MIX_W + wvm_pkg::S_W;
    localparam int EP_W = wvm_pkg::VAL_W + wvm_pkg::AMP_W;
    localparam int RP_W = wvm_pkg::F_W + wvm_pkg::RM_W;
    localparam logic signed [wvm_pkg::MIX_W:0] CLAMP_HI = 33'sd32767;
    localparam logic signed [wvm_pkg::MIX_W:0] CLAMP_LO = -33'sd32768;

    wvm_pkg::t_back_state                  r_state;
    wvm_pkg::t_back_state                  n_state;
    wvm_pkg::t_cmd                         r_cmd;
    logic [wvm_pkg::MIX_W-1:0]             r_mix;
    logic [wvm_pkg::MIX_W-1:0]             n_mix;
    logic [wvm_pkg::PHASE_W-1:0]           r_phase [wvm_pkg::CTR_DEPTH];
    logic signed [wvm_pkg::VAL_W-1:0]      r_wave_mem [wvm_pkg::TBL_DEPTH];
    logic signed [wvm_pkg::VAL_W-1:0]      r_rd_data;
    logic [wvm_pkg::F_W-1:0]               r_f15;
    logic [wvm_pkg::Q_W-1:0]               r_q0;
    logic [wvm_pkg::QS_W-1:0]              r_qs;
    logic [wvm_pkg::Q_W-1:0]               r_step;
    logic signed [wvm_pkg::S_W-1:0]        r_s;
    logic                                  r_out_valid;
    logic [wvm_pkg::SMP_W-1:0]             r_out_sample;
    logic [wvm_pkg::VOICE_W-1:0]           r_out_voice;

    logic                                  w_pop;
    logic                                  w_out_free;
    logic                                  w_mix_go;
    logic                                  w_tbl_we;
    logic                                  w_tbl_re;
    logic [wvm_pkg::TA_W-1:0]              w_wr_addr;
    logic [wvm_pkg::TA_W-1:0]              w_rd_addr;
    logic [wvm_pkg::PHASE_W-1:0]           w_m;
    logic [wvm_pkg::FMP_W-1:0]             w_fprod;
    logic [RP_W-1:0]                       w_rprod;
    logic [wvm_pkg::QS_W-1:0]              w_qs;
    logic [wvm_pkg::PHASE_W-1:0]           w_num;
    logic [wvm_pkg::PHASE_W-1:0]           w_phase;
    logic signed [wvm_pkg::VAL_W-1:0]      w_entry;
    logic signed [EP_W-1:0]                w_eprod;
    logic signed [wvm_pkg::S_W-1:0]        w_s;
    logic signed [MP_W-1:0]                w_mprod;
    logic signed [wvm_pkg::MIX_W:0]        w_sum;

    assign o_cmd_ready = (r_state == wvm_pkg::S_IDLE);
    assign w_pop       = o_cmd_ready && i_cmd_valid;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_mix_go    = (r_state == wvm_pkg::S_MIX) && (!r_cmd.last || w_out_free);
    assign o_out_valid = r_out_valid;
    assign o_sample    = r_out_sample;
    assign o_voice     = r_out_voice;

    // ---- sequencer ---------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wvm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        w_tbl_we = 1'b0;
        w_tbl_re = 1'b0;
        case (r_state)
            wvm_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.is_load) begin
                        w_tbl_we = i_cmd.wave_ok;
                    end else if (i_cmd.is_const) begin
                        n_state = wvm_pkg::S_SCALE;
                    end else begin
                        n_state = wvm_pkg::S_FMUL;
                    end
                end
            end
            wvm_pkg::S_FMUL:  n_state = wvm_pkg::S_RECIP;
            wvm_pkg::S_RECIP: n_state = wvm_pkg::S_CORR;
            wvm_pkg::S_CORR:  n_state = wvm_pkg::S_STEP;
            wvm_pkg::S_STEP:  n_state = wvm_pkg::S_PHASE;
            wvm_pkg::S_PHASE: begin
                w_tbl_re = 1'b1;
                n_state  = wvm_pkg::S_SCALE;
            end
            wvm_pkg::S_SCALE: n_state = wvm_pkg::S_MIX;
            wvm_pkg::S_MIX: begin
                // hold until the output register can take the sample
                if (w_mix_go) begin
                    n_state = wvm_pkg::S_IDLE;
                end
            end
            default: n_state = wvm_pkg::S_IDLE;
        endcase
    end

    // ---- datapath ------------------------------------------------------------
    always_comb begin
        w_m     = r_mix + wvm_pkg::FM_BIAS;
        w_fprod = wvm_pkg::FMP_W'(r_cmd.freq) * w_m[wvm_pkg::FMP_W-1:0];
        w_rprod = RP_W'(r_f15) * RP_W'(wvm_pkg::RECIP_M);
        w_qs    = wvm_pkg::QS_W'(wvm_pkg::Q_W'(r_q0 + 1'b1))
                * wvm_pkg::QS_W'(wvm_pkg::SAMPLE_RATE);
        w_num   = {r_f15, {wvm_pkg::STEP_SHIFT{1'b0}}};
        w_phase = (r_cmd.cvalid ? r_phase[r_cmd.ci] : '0)
                + wvm_pkg::PHASE_W'(r_step);
        w_wr_addr = {i_cmd.wave, i_cmd.idx};
        w_rd_addr = {r_cmd.wave, w_phase[wvm_pkg::SLOT_LSB +: wvm_pkg::SLOT_W]};
        w_entry = r_cmd.wave_ok ? r_rd_data : '0;
        w_eprod = EP_W'(w_entry) * EP_W'(r_cmd.amp);
        if (r_cmd.is_const) begin
            w_s = wvm_pkg::S_W'(r_cmd.amp) + wvm_pkg::S_W'(r_cmd.bias);
        end else begin
            w_s = wvm_pkg::S_W'($signed(w_eprod[EP_W-1:wvm_pkg::Q15]))
                + wvm_pkg::S_W'(r_cmd.bias);
        end
        w_mprod = MP_W'($signed(r_mix)) * MP_W'(r_s);
        w_sum   = (wvm_pkg::MIX_W + 1)'($signed(r_mix)) + (wvm_pkg::MIX_W + 1)'(r_s);
    end

    always_comb begin
        n_mix = r_mix;
        // clear the mix as the first track of a sample enters
        if (w_pop && !i_cmd.is_load && i_cmd.first) begin
            n_mix = '0;
        end
        if (w_mix_go) begin
            case (r_cmd.kind)
                wvm_pkg::KIND_MOD: begin
                    n_mix = w_mprod[wvm_pkg::Q15 +: wvm_pkg::MIX_W];
                end
                wvm_pkg::KIND_ADD: begin
                    if (w_sum > CLAMP_HI) begin
                        n_mix = wvm_pkg::MIX_W'(CLAMP_HI);
                    end else if (w_sum < CLAMP_LO) begin
                        n_mix = wvm_pkg::MIX_W'(CLAMP_LO);
                    end else begin
                        n_mix = wvm_pkg::MIX_W'(w_sum);
                    end
                end
                wvm_pkg::KIND_REPL, wvm_pkg::KIND_FM: begin
                    n_mix = wvm_pkg::MIX_W'(r_s);
                end
                default: n_mix = r_mix;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mix       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < wvm_pkg::CTR_DEPTH; i++) begin
                r_phase[i] <= '0;
            end
        end else begin
            r_mix <= n_mix;
            if ((r_state == wvm_pkg::S_PHASE) && r_cmd.cvalid) begin
                r_phase[r_cmd.ci] <= w_phase;
            end
            if (w_mix_go && r_cmd.last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_cmd <= i_cmd;
        end
        case (r_state)
            wvm_pkg::S_FMUL: begin
                r_f15 <= (r_cmd.kind == wvm_pkg::KIND_FM)
                       ? w_fprod[wvm_pkg::FM_SHIFT +: wvm_pkg::F_W]
                       : wvm_pkg::F_W'(r_cmd.freq);
            end
            wvm_pkg::S_RECIP: r_q0 <= wvm_pkg::Q_W'(w_rprod[RP_W-1:wvm_pkg::F_W]);
            wvm_pkg::S_CORR:  r_qs <= w_qs;
            wvm_pkg::S_STEP: begin
                // the estimate is at most one low; bump it when the next multiple fits
                r_step <= (64'(w_num) >= 64'(r_qs)) ? wvm_pkg::Q_W'(r_q0 + 1'b1) : r_q0;
            end
            wvm_pkg::S_SCALE: r_s <= w_s;
            default: ;
        endcase
        if (w_mix_go && r_cmd.last) begin
            r_out_sample <= n_mix[wvm_pkg::SMP_W-1:0];
            r_out_voice  <= r_cmd.voice;
        end
    end

    // ---- wave table memory ---------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_tbl_we) begin
            r_wave_mem[w_wr_addr] <= i_cmd.value;
        end
        if (w_tbl_re) begin
            r_rd_data <= r_wave_mem[w_rd_addr];
        end
    end

`ifndef SYNTHESIS
    a_out_from_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid))
        |-> ($past(r_state) == wvm_pkg::S_MIX && $past(r_cmd.last)))
        else $error("sample loaded outside the mix step of a last track");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wvm_pkg::S_STEP)
        |-> (64'(w_num) < 64'(r_qs) + 64'(wvm_pkg::SAMPLE_RATE)))
        else $error("reciprocal estimate more than one below the quotient");

    a_load_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && i_cmd.is_load) |=> (r_state == wvm_pkg::S_IDLE))
        else $error("load item left the sequencer busy");

    a_const_no_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wvm_pkg::S_PHASE) |-> !r_cmd.is_const)
        else $error("constant wave reached the phase step");
`endif

endmodule
`default_nettype wire

>>> design/wavetable_voice_mixer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wavetable_voice_mixer_unit
// Wavetable oscillator bank with per-voice, per-track phase and one running mix.
// ----------------------------------------------------------------------------
// Usage
//   Slave stream: one item per handshake (tvalid & tready). tuser[0] picks a
//   table load (0) or a track operation (1); tuser[3:1] is the combine kind;
//   tlast asks for a sample after the track. Master stream: one sample item
//   per track item with tlast set, tagged with its voice.
//   Sequencing: the back sequencer takes a load in its idle state; a
//   constant-wave track passes the scale and mix states; a table-wave track
//   runs the phase-step chain (frequency multiply, reciprocal multiply,
//   correction multiply, compare, counter add and table read, scale
//   multiply, mix multiply), one state per step. It takes no new item until
//   it is back in its idle state. An item passes the input register and the
//   queue, then the sequencer states, then the output register.
//   A four-deep queue lets the input side keep taking items while a sample
//   waits; a stalled receiver holds the sequencer at its mix step, then the
//   queue fills, then tready drops.
//   Reset: phase counters and the running mix go to zero. The wave table is
//   not cleared; every entry must be loaded before a track reads it.
// ----------------------------------------------------------------------------
module wavetable_voice_mixer_unit (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    // voice[1:0] track[3:2] first_of_sample[4] wave[8:5] freq[23:9]
    // amp[39:24] bias[55:40] table_index[60:56] table_value[77:61] zero[79:78]
    input  wire [wvm_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // last_of_sample
    input  wire                            s_axis_tlast,
    // action[0] op_kind[3:1]
    input  wire [wvm_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    // sample[15:0] voice_out[17:16] zero[23:18]
    output logic [wvm_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    localparam int PAD_W = wvm_pkg::M_TDATA_W - wvm_pkg::SMP_W - wvm_pkg::VOICE_W;

    logic                          w_fr_valid;
    logic                          w_fr_ready;
    wvm_pkg::t_cmd                 w_fr_cmd;
    logic                          w_q_valid;
    logic                          w_q_ready;
    wvm_pkg::t_cmd                 w_q_cmd;
    logic [wvm_pkg::SMP_W-1:0]     w_sample;
    logic [wvm_pkg::VOICE_W-1:0]   w_voice;

    // decode and register incoming items
    wvm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .o_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tlast   (s_axis_tlast),
        .i_s_tuser   (s_axis_tuser),
        .o_cmd_valid (w_fr_valid),
        .i_cmd_ready (w_fr_ready),
        .o_cmd       (w_fr_cmd)
    );

    // buffer commands so the front keeps accepting while the back is busy
    wvm_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fr_valid),
        .o_push_ready (w_fr_ready),
        .i_push_data  (w_fr_cmd),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_pop_data   (w_q_cmd)
    );

    // execute loads and track operations, drive the sample register
    wvm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .o_cmd_ready (w_q_ready),
        .i_cmd       (w_q_cmd),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_sample    (w_sample),
        .o_voice     (w_voice)
    );

    // pack the result item, sample in the low bits
    assign m_axis_tdata = {{PAD_W{1'b0}}, w_voice, w_sample};

endmodule
`default_nettype wire

>>> tb/wavetable_voice_mixer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wavetable_voice_mixer_unit_tb
// Self-checking bench for the wavetable voice mixer. A queue of items feeds a
// stream driver; every accepted item also steps a local mirror of the wave
// table, phase counters and running mix, which queues the samples the block
// should emit. A monitor checks each sample and its voice tag in order while
// both stream sides idle at random, and once the output stalls long enough to
// back the block up into its input.
// ----------------------------------------------------------------------------
module wavetable_voice_mixer_unit_tb;

    // Combine kinds the block treats as none
    localparam logic [wvm_pkg::KIND_W-1:0] KIND_RSV5 = 3'd5;
    localparam logic [wvm_pkg::KIND_W-1:0] KIND_RSV6 = 3'd6;
    localparam logic [wvm_pkg::KIND_W-1:0] KIND_RSV7 = 3'd7;

    localparam int HOLD_CYCLES = 300;   // long output stall in the last phase
    localparam int QUIET_LIMIT = 4000;  // cycles with no item moving on either side
    localparam int TAIL_CYCLES = 50;    // settle time after the last sample
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic                             action;
        logic [wvm_pkg::VOICE_W-1:0]      voice;
        logic [wvm_pkg::TRACK_W-1:0]      track;
        logic                             first;
        logic                             last;
        logic [wvm_pkg::KIND_W-1:0]       kind;
        logic [wvm_pkg::WAVE_W-1:0]       wave;
        logic [wvm_pkg::FREQ_W-1:0]       freq;
        logic signed [wvm_pkg::AMP_W-1:0] amp;
        logic signed [wvm_pkg::AMP_W-1:0] bias;
        logic [wvm_pkg::IDX_W-1:0]        idx;
        logic signed [wvm_pkg::VAL_W-1:0] val;
    } t_mixer_item;

    typedef struct {
        logic [wvm_pkg::SMP_W-1:0]   sample;
        logic [wvm_pkg::VOICE_W-1:0] voice;
    } t_voice_sample;

    // ------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------
    logic                            i_clk;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [wvm_pkg::S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                            s_axis_tlast  = 1'b0;
    logic [wvm_pkg::S_TUSER_W-1:0]   s_axis_tuser  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [wvm_pkg::M_TDATA_W-1:0]   m_axis_tdata;

    wavetable_voice_mixer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hold reset low at start-up, then release it for good.
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    t_mixer_item   pending_items[$];     // items waiting for the driver
    t_voice_sample expected_samples[$];  // samples the block still owes
    t_mixer_item   tx_item;              // item currently offered

    int unsigned tx_idle_pct = 37;
    int unsigned rx_idle_pct = 77;
    bit          hold_armed  = 1'b0;

    int err_count   = 0;
    int n_loads     = 0;
    int n_tracks    = 0;
    int n_samples   = 0;

    // Mirror of the block state, stepped on each accepted item
    logic signed [wvm_pkg::VAL_W-1:0] tbl_mirror[wvm_pkg::TBL_DEPTH];
    logic [wvm_pkg::PHASE_W-1:0]      phase_mirror[wvm_pkg::CTR_DEPTH];
    logic [wvm_pkg::MIX_W-1:0]        mix_mirror = '0;

    // Generator-side record of which table entries have been loaded
    bit entry_loaded[wvm_pkg::TBL_DEPTH];

    initial begin
        foreach (phase_mirror[i]) phase_mirror[i] = '0;
        foreach (tbl_mirror[i]) tbl_mirror[i] = '0;
        foreach (entry_loaded[i]) entry_loaded[i] = 1'b0;
    end

    function automatic void flag_error(string msg);
        if (err_count < MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endfunction

    // ------------------------------------------------------------------
    // Mixer mirror: apply one accepted item, queue the sample it causes
    // ------------------------------------------------------------------
    function automatic void advance_mixer(t_mixer_item it);
        logic [wvm_pkg::PHASE_W-1:0] f;
        logic [wvm_pkg::PHASE_W-1:0] fm_scale;
        logic [wvm_pkg::PHASE_W-1:0] prod;
        logic [wvm_pkg::PHASE_W-1:0] step;
        logic [wvm_pkg::PHASE_W-1:0] phase;
        logic [wvm_pkg::SLOT_W-1:0]  slot;
        longint                      entry;
        longint                      s;
        longint                      ms;
        longint                      acc;
        int                          ci;
        t_voice_sample               want;

        if (it.action == wvm_pkg::ACT_LOAD) begin
            if (int'(it.wave) < wvm_pkg::NUM_WAVES)
                tbl_mirror[int'(it.wave) * wvm_pkg::NUM_WAVE_SAMPLES + int'(it.idx)] = it.val;
            return;
        end

        // Clear the mix before the first track of a sample
        if (it.first)
            mix_mirror = '0;

        if (it.wave == wvm_pkg::CONST_WAVE) begin
            // Constant wave: amp + bias, counter stays put
            s = longint'(it.amp) + longint'(it.bias);
        end else begin
            f = wvm_pkg::PHASE_W'(it.freq);
            if (it.kind == wvm_pkg::KIND_FM) begin
                // Scale the frequency by (mix + 2^15) / 2^16, all mod 2^32
                fm_scale = mix_mirror + wvm_pkg::FM_BIAS;
                prod     = f * fm_scale;
                f        = prod >> wvm_pkg::FM_SHIFT;
            end
            prod  = f << wvm_pkg::STEP_SHIFT;
            step  = prod / wvm_pkg::PHASE_W'(wvm_pkg::SAMPLE_RATE);
            ci    = int'(it.voice) * wvm_pkg::NUM_TRACKS + int'(it.track);
            phase = phase_mirror[ci] + step;
            phase_mirror[ci] = phase;
            slot  = phase[wvm_pkg::SLOT_LSB +: wvm_pkg::SLOT_W];
            entry = 0;
            if (int'(it.wave) < wvm_pkg::NUM_WAVES)
                entry = longint'(tbl_mirror[int'(it.wave) * wvm_pkg::NUM_WAVE_SAMPLES
                                            + int'(slot)]);
            s = ((entry * longint'(it.amp)) >>> wvm_pkg::Q15) + longint'(it.bias);
        end

        ms = longint'(signed'(mix_mirror));
        case (it.kind)
            wvm_pkg::KIND_MOD: begin
                acc = (ms * s) >>> wvm_pkg::Q15;
                mix_mirror = acc[wvm_pkg::MIX_W-1:0];
            end
            wvm_pkg::KIND_ADD: begin
                acc = ms + s;
                if (acc < -32768)
                    acc = -32768;
                else if (acc > 32767)
                    acc = 32767;
                mix_mirror = acc[wvm_pkg::MIX_W-1:0];
            end
            wvm_pkg::KIND_REPL, wvm_pkg::KIND_FM: begin
                mix_mirror = s[wvm_pkg::MIX_W-1:0];
            end
            default: begin
                // none and spare kinds leave the mix alone
            end
        endcase

        if (it.last) begin
            want.sample = mix_mirror[wvm_pkg::SMP_W-1:0];
            want.voice  = it.voice;
            expected_samples.push_back(want);
        end
    endfunction

    // ------------------------------------------------------------------
    // Random field helpers
    // ------------------------------------------------------------------
    function automatic logic signed [wvm_pkg::AMP_W-1:0] rand_level();
        case ($urandom_range(0, 7))
            0:       return wvm_pkg::AMP_W'(16'h8000);
            1:       return wvm_pkg::AMP_W'(16'h7FFF);
            2:       return wvm_pkg::AMP_W'($urandom_range(0, 255) - 128);
            default: return wvm_pkg::AMP_W'($urandom());
        endcase
    endfunction

    function automatic logic signed [wvm_pkg::VAL_W-1:0] rand_entry();
        case ($urandom_range(0, 11))
            0:       return wvm_pkg::VAL_W'(17'h10000);
            1:       return wvm_pkg::VAL_W'(17'h0FFFF);
            2:       return wvm_pkg::VAL_W'(17'h1FFFF);
            default: return wvm_pkg::VAL_W'($urandom());
        endcase
    endfunction

    function automatic logic [wvm_pkg::FREQ_W-1:0] rand_freq();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return wvm_pkg::FREQ_W'($urandom_range(20, 4000));
            default: return wvm_pkg::FREQ_W'($urandom());
        endcase
    endfunction

    function automatic logic [wvm_pkg::KIND_W-1:0] pick_kind();
        if ($urandom_range(0, 99) < 85)
            return wvm_pkg::KIND_W'($urandom_range(int'(wvm_pkg::KIND_NONE),
                                                   int'(wvm_pkg::KIND_FM)));
        return wvm_pkg::KIND_W'($urandom_range(int'(KIND_RSV5), int'(KIND_RSV7)));
    endfunction

    function automatic bit wave_loaded(int w);
        for (int i = 0; i < wvm_pkg::NUM_WAVE_SAMPLES; i++)
            if (!entry_loaded[w * wvm_pkg::NUM_WAVE_SAMPLES + i])
                return 1'b0;
        return 1'b1;
    endfunction

    // Constant wave, or a table wave whose every entry is loaded
    function automatic logic [wvm_pkg::WAVE_W-1:0] pick_wave();
        logic [wvm_pkg::WAVE_W-1:0] ready[$];
        if ($urandom_range(0, 99) < 20)
            return wvm_pkg::CONST_WAVE;
        for (int w = 0; w < wvm_pkg::NUM_WAVES; w++)
            if (w != int'(wvm_pkg::CONST_WAVE) && wave_loaded(w))
                ready.push_back(wvm_pkg::WAVE_W'(w));
        return ready[$urandom_range(0, ready.size() - 1)];
    endfunction

    function automatic t_mixer_item rand_fields();
        t_mixer_item it;
        it.action = 1'($urandom());
        it.voice  = wvm_pkg::VOICE_W'($urandom());
        it.track  = wvm_pkg::TRACK_W'($urandom());
        it.first  = 1'($urandom());
        it.last   = 1'($urandom());
        it.kind   = wvm_pkg::KIND_W'($urandom());
        it.wave   = wvm_pkg::WAVE_W'($urandom());
        it.freq   = rand_freq();
        it.amp    = rand_level();
        it.bias   = rand_level();
        it.idx    = wvm_pkg::IDX_W'($urandom());
        it.val    = rand_entry();
        return it;
    endfunction

    // Queue a load; the remaining fields carry random junk
    task automatic push_load(logic [wvm_pkg::WAVE_W-1:0] w, logic [wvm_pkg::IDX_W-1:0] ix,
                             logic signed [wvm_pkg::VAL_W-1:0] v);
        t_mixer_item it;
        it        = rand_fields();
        it.action = wvm_pkg::ACT_LOAD;
        it.wave   = w;
        it.idx    = ix;
        it.val    = v;
        if (int'(w) < wvm_pkg::NUM_WAVES)
            entry_loaded[int'(w) * wvm_pkg::NUM_WAVE_SAMPLES + int'(ix)] = 1'b1;
        pending_items.push_back(it);
    endtask

    task automatic push_track(logic [wvm_pkg::VOICE_W-1:0] v, logic [wvm_pkg::TRACK_W-1:0] t,
                              logic fst, logic lst, logic [wvm_pkg::KIND_W-1:0] k,
                              logic [wvm_pkg::WAVE_W-1:0] w, logic [wvm_pkg::FREQ_W-1:0] fr,
                              logic signed [wvm_pkg::AMP_W-1:0] a,
                              logic signed [wvm_pkg::AMP_W-1:0] b);
        t_mixer_item it;
        it        = rand_fields();
        it.action = wvm_pkg::ACT_TRACK;
        it.voice  = v;
        it.track  = t;
        it.first  = fst;
        it.last   = lst;
        it.kind   = k;
        it.wave   = w;
        it.freq   = fr;
        it.amp    = a;
        it.bias   = b;
        pending_items.push_back(it);
    endtask

    // Mostly whole samples (first .. last on one voice), the rest loose
    // tracks with random flags and table rewrites.
    task automatic queue_random_items(int n);
        int                          made;
        int                          len;
        logic [wvm_pkg::VOICE_W-1:0] v;
        made = 0;
        while (made < n) begin
            case ($urandom_range(0, 99)) inside
                [0:14]: begin
                    push_load(wvm_pkg::WAVE_W'($urandom()), wvm_pkg::IDX_W'($urandom()),
                              rand_entry());
                    made++;
                end
                [15:79]: begin
                    len = $urandom_range(1, 4);
                    v   = wvm_pkg::VOICE_W'($urandom());
                    for (int k = 0; k < len; k++)
                        push_track(v, wvm_pkg::TRACK_W'($urandom()), k == 0, k == len - 1,
                                   pick_kind(), pick_wave(), rand_freq(),
                                   rand_level(), rand_level());
                    made += len;
                end
                default: begin
                    push_track(wvm_pkg::VOICE_W'($urandom()), wvm_pkg::TRACK_W'($urandom()),
                               1'($urandom()), 1'($urandom()),
                               wvm_pkg::KIND_W'($urandom()),
                               pick_wave(), rand_freq(), rand_level(), rand_level());
                    made++;
                end
            endcase
        end
    endtask

    // Block until every queued item is in and every owed sample is out.
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_axis_tvalid || expected_samples.size() != 0)
            @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int preload_waves[4] = '{0, 5, 10, 14};

        // Fill a handful of waves completely; tracks only read these.
        foreach (preload_waves[w])
            for (int i = 0; i < wvm_pkg::NUM_WAVE_SAMPLES; i++)
                push_load(wvm_pkg::WAVE_W'(preload_waves[w]), wvm_pkg::IDX_W'(i),
                          rand_entry());

        // Constant wave at the extremes: result wider than 16 bits, replace
        push_track(0, 0, 1, 1, wvm_pkg::KIND_REPL, wvm_pkg::CONST_WAVE, 0,
                   16'sh7FFF, 16'sh7FFF);
        push_track(1, 1, 1, 1, wvm_pkg::KIND_REPL, wvm_pkg::CONST_WAVE, 0,
                   16'sh8000, 16'sh8000);
        // Add clamp, high then low
        push_track(2, 2, 1, 0, wvm_pkg::KIND_ADD, wvm_pkg::CONST_WAVE, 0, 16'sh7FFF, 0);
        push_track(2, 3, 0, 1, wvm_pkg::KIND_ADD, wvm_pkg::CONST_WAVE, 0, 16'sh7FFF, 0);
        push_track(3, 0, 1, 0, wvm_pkg::KIND_ADD, wvm_pkg::CONST_WAVE, 0, 16'sh8000, 0);
        push_track(3, 1, 0, 1, wvm_pkg::KIND_ADD, wvm_pkg::CONST_WAVE, 0,
                   16'sh8000, 16'sh8000);
        // Modulate by a table wave at the top frequency
        push_track(0, 1, 1, 0, wvm_pkg::KIND_REPL, wvm_pkg::CONST_WAVE, 0, 16'sh4000, 0);
        push_track(0, 2, 0, 1, wvm_pkg::KIND_MOD, 0, 15'h7FFF, 16'sh8000, 16'sh7FFF);
        // Zero frequency: counter holds, same slot twice
        push_track(1, 0, 1, 1, wvm_pkg::KIND_REPL, 5, 0, 16'sh7FFF, 16'sh8000);
        push_track(1, 0, 1, 1, wvm_pkg::KIND_REPL, 5, 0, 16'sh7FFF, 16'sh8000);
        // Frequency modulation from a large negative mix
        push_track(2, 0, 1, 0, wvm_pkg::KIND_REPL, wvm_pkg::CONST_WAVE, 0,
                   16'sh8000, 16'sh8000);
        push_track(2, 0, 0, 1, wvm_pkg::KIND_FM, 10, 15'h7FFF, 16'sh7FFF, 0);
        // Kind none still turns the oscillator
        push_track(3, 3, 1, 0, wvm_pkg::KIND_REPL, wvm_pkg::CONST_WAVE, 0, 1000, 0);
        push_track(3, 3, 0, 1, wvm_pkg::KIND_NONE, 14, 5000, 16'sh7FFF, 0);
        // Spare kinds, mix carried over from earlier samples
        push_track(0, 3, 0, 1, KIND_RSV5, 0, 777, 16'sh7FFF, 0);
        push_track(1, 2, 0, 1, KIND_RSV6, wvm_pkg::CONST_WAVE, 0, 123, 456);
        push_track(2, 1, 0, 1, KIND_RSV7, 10, 440, 16'sh8000, 16'sh7FFF);
        // Load to the constant wave slot, with tracking flags set: no sample
        push_load(wvm_pkg::CONST_WAVE, 5'd31, wvm_pkg::VAL_W'(17'h10000));
        pending_items[$].last = 1'b1;
        pending_items[$].kind = wvm_pkg::KIND_MOD;
        // Frequency modulation on the constant wave is plain replace
        push_track(3, 2, 1, 1, wvm_pkg::KIND_FM, wvm_pkg::CONST_WAVE, 15'h7FFF, 5, 5);
        push_track(0, 0, 1, 0, wvm_pkg::KIND_REPL, 14, 1, 16'shFFFF, 16'shFFFF);
        push_track(0, 0, 0, 1, wvm_pkg::KIND_MOD, 14, 12345, 16'sh7FFF, 16'sh7FFF);
        // Middle of a sample without flags, then close it
        push_track(1, 3, 0, 0, wvm_pkg::KIND_ADD, 0, 100, 16'sh2000, 16'sh0100);
        push_track(1, 3, 0, 1, wvm_pkg::KIND_MOD, wvm_pkg::CONST_WAVE, 0, 16'shFFFF, 0);

        // Phase one: sender idles 37 %, receiver 77 %
        queue_random_items(100);
        wait_drained();

        // Phase two: swapped
        tx_idle_pct = 77;
        rx_idle_pct = 37;
        queue_random_items(100);
        wait_drained();

        // Phase three: no idling, and one long output stall up front
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_armed  = 1'b1;
        queue_random_items(100);
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("run: %0d table loads, %0d track ops, %0d samples checked",
                 n_loads, n_tracks, n_samples);
        $display("run: three idle patterns, one %0d-cycle output stall, %0d mismatches",
                 HOLD_CYCLES, err_count);
        if (err_count == 0) begin
            $display("wavetable_voice_mixer_unit_tb: clean");
        end else begin
            $display("wavetable_voice_mixer_unit_tb: errors");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Input driver: hold the offered item until taken, then advance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : sender
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                advance_mixer(tx_item);
                if (tx_item.action == wvm_pkg::ACT_LOAD)
                    n_loads++;
                else
                    n_tracks++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    tx_item = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {2'b00, tx_item.val, tx_item.idx, tx_item.bias,
                                      tx_item.amp, tx_item.freq, tx_item.wave,
                                      tx_item.first, tx_item.track, tx_item.voice};
                    s_axis_tlast  <= tx_item.last;
                    s_axis_tuser  <= {tx_item.kind, tx_item.action};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: random ready, plus one long hold-off when armed
    // ------------------------------------------------------------------
    int hold_left  = 0;
    bit hold_taken = 1'b0;

    always @(posedge i_clk) begin : receiver
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_armed && !hold_taken) begin
            hold_taken    <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each sample with the oldest one owed
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_voice_sample               want;
        logic [wvm_pkg::SMP_W-1:0]   got_sample;
        logic [wvm_pkg::VOICE_W-1:0] got_voice;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_sample = m_axis_tdata[wvm_pkg::SMP_W-1:0];
            got_voice  = m_axis_tdata[wvm_pkg::SMP_W +: wvm_pkg::VOICE_W];
            if (expected_samples.size() == 0) begin
                flag_error($sformatf("sample %h voice %0d with nothing owed",
                                     got_sample, got_voice));
            end else begin
                want = expected_samples.pop_front();
                n_samples++;
                if (got_sample !== want.sample)
                    flag_error($sformatf("sample #%0d: expected %h, got %h",
                                         n_samples, want.sample, got_sample));
                if (got_voice !== want.voice)
                    flag_error($sformatf("sample #%0d voice: expected %0d, got %0d",
                                         n_samples, want.voice, got_voice));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no item moves for too long
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready)
                     || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles, %0d samples still owed",
                     QUIET_LIMIT, expected_samples.size());
            $display("wavetable_voice_mixer_unit_tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

>>> wavetable_voice_mixer_unit.f
design/wvm_pkg.sv
design/wvm_front.sv
design/wvm_fifo.sv
design/wvm_back.sv
design/wavetable_voice_mixer_unit.sv
tb/wavetable_voice_mixer_unit_tb.sv
